// ===== rtl/tats_pkg.sv =====
// ----------------------------------------------------------------------------
// tats_pkg
// Types and constants shared by the alarm tone sequencer modules.
// ----------------------------------------------------------------------------
package tats_pkg;

  localparam int unsigned CFG_AW = 5;
  localparam int unsigned CFG_DW = 32;

  // register indexes (paddr[4:2])
  localparam logic [2:0] REG_ALARM_ENABLE   = 3'd0;
  localparam logic [2:0] REG_LOW_THRESHOLD  = 3'd1;
  localparam logic [2:0] REG_HIGH_THRESHOLD = 3'd2;
  localparam logic [2:0] REG_TONE_HIGH_HZ   = 3'd3;
  localparam logic [2:0] REG_TONE_LOW_HZ    = 3'd4;
  localparam logic [2:0] REG_STEP_MS        = 3'd5;
  localparam logic [2:0] REG_PAUSE_MS       = 3'd6;
  localparam logic [2:0] REG_DRIVE_DUTY     = 3'd7;

  localparam logic signed [15:0] HIGH_THRESHOLD_RST = 16'sd1600;

  // sequence steps: high, low, high, low, pause
  localparam logic [2:0] SEQ_PAUSE = 3'd4;

  typedef struct packed {
    logic [31:0]        now_ms;
    logic               temp_valid;
    logic signed [15:0] temperature;
    logic [31:0]        test_until_ms;
  } in_item_t;

  typedef struct packed {
    logic [15:0] tone_hz;
    logic [15:0] duty_out;
  } out_item_t;

  typedef struct packed {
    logic               alarm_enable;
    logic signed [15:0] low_threshold;
    logic signed [15:0] high_threshold;
    logic [15:0]        tone_high_hz;
    logic [15:0]        tone_low_hz;
    logic [31:0]        step_ms;
    logic [31:0]        pause_ms;
    logic [15:0]        drive_duty;
  } cfg_t;

  // (step + 1) mod 5 on the 3-bit step code
  function automatic logic [2:0] next_step(input logic [2:0] s);
    logic [2:0] r;
    case (s)
      3'd0:    r = 3'd1;
      3'd1:    r = 3'd2;
      3'd2:    r = 3'd3;
      3'd3:    r = 3'd4;
      3'd4:    r = 3'd0;
      3'd5:    r = 3'd1;
      3'd6:    r = 3'd2;
      3'd7:    r = 3'd3;
      default: r = 3'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/tats_regs.sv =====
// ----------------------------------------------------------------------------
// tats_regs
// APB-style configuration register file for the alarm tone sequencer.
// ----------------------------------------------------------------------------
module tats_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [tats_pkg::CFG_AW-1:0]  paddr,
  input  logic [tats_pkg::CFG_DW-1:0]  pwdata,
  output logic [tats_pkg::CFG_DW-1:0]  prdata,
  output logic                         pready,
  output tats_pkg::cfg_t               cfg
);
  import tats_pkg::*;

  cfg_t       cfg_r;
  logic [2:0] reg_idx;
  logic       wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.alarm_enable   <= 1'b0;
      cfg_r.low_threshold  <= '0;
      cfg_r.high_threshold <= HIGH_THRESHOLD_RST;
      cfg_r.tone_high_hz   <= '0;
      cfg_r.tone_low_hz    <= '0;
      cfg_r.step_ms        <= '0;
      cfg_r.pause_ms       <= '0;
      cfg_r.drive_duty     <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_ALARM_ENABLE:   cfg_r.alarm_enable   <= pwdata[0];
        REG_LOW_THRESHOLD:  cfg_r.low_threshold  <= pwdata[15:0];
        REG_HIGH_THRESHOLD: cfg_r.high_threshold <= pwdata[15:0];
        REG_TONE_HIGH_HZ:   cfg_r.tone_high_hz   <= pwdata[15:0];
        REG_TONE_LOW_HZ:    cfg_r.tone_low_hz    <= pwdata[15:0];
        REG_STEP_MS:        cfg_r.step_ms        <= pwdata;
        REG_PAUSE_MS:       cfg_r.pause_ms       <= pwdata;
        REG_DRIVE_DUTY:     cfg_r.drive_duty     <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_ALARM_ENABLE:   prdata = {31'd0, cfg_r.alarm_enable};
      REG_LOW_THRESHOLD:  prdata = {{16{cfg_r.low_threshold[15]}}, cfg_r.low_threshold};
      REG_HIGH_THRESHOLD: prdata = {{16{cfg_r.high_threshold[15]}}, cfg_r.high_threshold};
      REG_TONE_HIGH_HZ:   prdata = {16'd0, cfg_r.tone_high_hz};
      REG_TONE_LOW_HZ:    prdata = {16'd0, cfg_r.tone_low_hz};
      REG_STEP_MS:        prdata = cfg_r.step_ms;
      REG_PAUSE_MS:       prdata = cfg_r.pause_ms;
      REG_DRIVE_DUTY:     prdata = {16'd0, cfg_r.drive_duty};
      default:            prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/temperature_alarm_tone_sequencer_unit.sv =====
// ----------------------------------------------------------------------------
// temperature_alarm_tone_sequencer_unit
// Alarm detector and five-step piezo tone sequencer, one tick per transaction.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one update tick per transaction (time, temperature, test time).
//   out_* : one tone command (tone_hz, duty_out) per tick that writes the
//           piezo; ticks that change nothing produce no transaction.
//   psel/penable/pwrite/paddr/pwdata/prdata/pready : register port, register
//           i at byte address 4*i; write only while the unit is idle.
// Pipeline: a tick is captured in an input register, evaluated against the
//   sequencer state once the output register is free, and its command lands
//   in the output register, which raises out_valid.
// Throughput: one tick per cycle while out_ready is high; the state update
//   (compare, one 32-bit add, step increment) closes the loop on each tick.
// Reset: sequencer idle (not beeping, step 0, deadline 0), registers at
//   their reset values, both pipeline registers empty.
// Stall: while out_ready is low and a command waits, the input register
//   holds and in_ready drops once it is full; nothing is dropped.
// ----------------------------------------------------------------------------
module temperature_alarm_tone_sequencer_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  tats_pkg::in_item_t           in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output tats_pkg::out_item_t          out_data,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [tats_pkg::CFG_AW-1:0]  paddr,
  input  logic [tats_pkg::CFG_DW-1:0]  pwdata,
  output logic [tats_pkg::CFG_DW-1:0]  prdata,
  output logic                         pready
);
  import tats_pkg::*;

  cfg_t cfg;

  tats_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // input stage
  logic      s1_valid_r;
  in_item_t  s1_item_r;
  // sequencer state
  logic        beeping_r, beeping_nxt;
  logic [2:0]  seq_step_r, seq_step_nxt;
  logic [31:0] nst_r, nst_nxt;
  // output stage
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_item_r, out_item_nxt;

  logic        out_free, s1_fire;
  logic        thresh, active, fire, res;
  logic [2:0]  base_step;
  logic [31:0] base_nst, diff, dur;
  logic [15:0] hz;

  assign out_free = !out_valid_r || out_ready;
  assign s1_fire  = s1_valid_r && out_free;
  assign in_ready = !s1_valid_r || s1_fire;

  always_comb begin
    thresh = cfg.alarm_enable && s1_item_r.temp_valid &&
             ((s1_item_r.temperature < cfg.low_threshold) ||
              (s1_item_r.temperature > cfg.high_threshold));
    active = thresh || ((s1_item_r.test_until_ms != 32'd0) &&
                        (s1_item_r.now_ms <= s1_item_r.test_until_ms));
    base_step = beeping_r ? seq_step_r : 3'd0;
    base_nst  = beeping_r ? nst_r : 32'd0;
    diff      = s1_item_r.now_ms - base_nst;
    fire      = (base_nst == 32'd0) || !diff[31];

    case (base_step)
      3'd0, 3'd2: hz = cfg.tone_high_hz;
      3'd1, 3'd3: hz = cfg.tone_low_hz;
      default:    hz = 16'd0;
    endcase
    dur = (base_step < SEQ_PAUSE) ? cfg.step_ms : cfg.pause_ms;

    beeping_nxt  = beeping_r;
    seq_step_nxt = seq_step_r;
    nst_nxt      = nst_r;
    res          = 1'b0;
    if (!active) begin
      beeping_nxt  = 1'b0;
      seq_step_nxt = 3'd0;
      nst_nxt      = 32'd0;
      res          = beeping_r;
      hz           = 16'd0;
    end else begin
      beeping_nxt  = 1'b1;
      seq_step_nxt = base_step;
      nst_nxt      = base_nst;
      if (fire) begin
        seq_step_nxt = next_step(base_step);
        nst_nxt      = s1_item_r.now_ms + dur;
        res          = 1'b1;
      end
    end

    out_item_nxt.tone_hz  = hz;
    out_item_nxt.duty_out = (hz != 16'd0) ? cfg.drive_duty : 16'd0;
    out_valid_nxt = s1_fire ? res : (out_valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      beeping_r   <= 1'b0;
      seq_step_r  <= 3'd0;
      nst_r       <= 32'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (s1_fire) begin
        beeping_r  <= beeping_nxt;
        seq_step_r <= seq_step_nxt;
        nst_r      <= nst_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_item_r <= in_data;
    end
    if (s1_fire && res) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  // idle sequencer always parks at step 0 with the deadline cleared
  a_idle_parked: assert property (@(posedge clk) disable iff (!rst_n)
    !beeping_r |-> (seq_step_r == 3'd0 && nst_r == 32'd0))
    else $error("sequencer idle but not parked");

  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    seq_step_r <= SEQ_PAUSE)
    else $error("sequence step out of range");

  a_silent_duty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_item_r.tone_hz != 16'd0 || out_item_r.duty_out == 16'd0))
    else $error("duty driven during silence");

  // a held command must not be overwritten by a processed tick
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !s1_fire)
    else $error("tick evaluated while command stalled");

  a_clear_silence: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && beeping_r && !beeping_nxt) |=> (out_valid_r && out_item_r.tone_hz == 16'd0))
    else $error("alarm clear without silence command");

endmodule
